// ===== design/sps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the seeded permutation shuffler.
// ----------------------------------------------------------------------------
package sps_pkg;
  // depth of the permutation store
  localparam int unsigned MaxLength = 131072;

  localparam logic [63:0] SmGamma = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SmMul1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SmMul2  = 64'h94d049bb133111eb;

  localparam logic [0:0] CfgSeed   = 1'b0;
  localparam logic [0:0] CfgLength = 1'b1;

  localparam logic KindShuffle = 1'b0;
  localparam logic KindRead    = 1'b1;

  // multiplier request/response between sequencer and shared unit
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;
endpackage
`default_nettype wire

// ===== design/seeded_permutation_shuffler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeded_permutation_shuffler_top
// Seeded Fisher-Yates permutation store with indexed read-back.
// ----------------------------------------------------------------------------
// A read transaction reads the store in S_RD0, registers the result in S_RD1
// and presents it until it is accepted; the block takes no new item before
// it is back in S_IDLE. A shuffle transaction of length L fills the store
// with the identity and hashes the seed; then, per entry, it runs three
// SplitMix64 evaluations (two passes of the shared multiplier each), a key
// multiply, a bit-serial remainder, a swap through the store and a loop step.
// The single shared multiplier and the bit-serial remainder set most of the
// shuffle time. The store is one single-port memory; it is never cleared.
module seeded_permutation_shuffler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] epoch_i,
  input  wire logic [16:0] position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      entry_value_o,
  output logic             read_error_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import sps_pkg::*;

  localparam int unsigned AW = $clog2(MaxLength);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] MaxLen = LW'(MaxLength);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0,  S_RD0 = 5'd1,  S_RD1 = 5'd2,
                         S_RDOUT = 5'd3, S_FILL = 5'd4, S_SM_ADD = 5'd5,
                         S_SM_M1 = 5'd6, S_SM_W1 = 5'd7, S_SM_M2 = 5'd8,
                         S_SM_W2 = 5'd9, S_SM_FIN = 5'd10, S_LOOP = 5'd11,
                         S_HASH_E = 5'd12, S_DIV = 5'd13, S_DIVW = 5'd14,
                         S_SW0 = 5'd15, S_SW1 = 5'd16, S_SW2 = 5'd17,
                         S_SW3 = 5'd18, S_MULE = 5'd19, S_MULEW = 5'd20;
  // what a finished hash feeds next
  localparam logic [1:0] H_SEED = 2'd0, H_KEY = 2'd1, H_MID = 2'd2, H_OUT = 2'd3;

  logic [4:0]    st_q, st_d;
  logic [1:0]    hsel_q, hsel_d;
  logic [63:0]   seed_q, seed_d;
  logic [LW-1:0] plen_q, plen_d, llen_q, llen_d, len_q, len_d;
  logic          once_q, once_d;
  logic [63:0]   smix_q, smix_d, z_q, z_d, h_q, h_d;
  logic [31:0]   epoch_q, epoch_d;
  logic [LW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d, pos_q, pos_d;
  logic [16:0]   ti_q, ti_d, val_q, val_d;
  logic          err_q, err_d, ovalid_q, ovalid_d;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic        dstart, ddone;
  logic [LW-1:0] drem;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [16:0]   mem_wdata, mem_rdata;
  logic [16:0]   mem [MaxLength];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_addr];
  end

  sps_mul64 u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  sps_divmod #(.DW(LW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(h_q), .den_i(i_q + LW'(1)),
    .done_o(ddone), .rem_o(drem)
  );

  logic [63:0] cfg_len;
  assign cfg_len = {46'd0, cfg_data_i[17:0]};

  always_comb begin
    st_d = st_q; hsel_d = hsel_q; seed_d = seed_q; plen_d = plen_q;
    llen_d = llen_q; len_d = len_q; once_d = once_q; smix_d = smix_q;
    z_d = z_q; h_d = h_q; epoch_d = epoch_q; i_d = i_q; j_d = j_q;
    pos_d = pos_q; ti_d = ti_q; val_d = val_q; err_d = err_q;
    ovalid_d = ovalid_q;
    mreq = '0; dstart = 1'b0;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = pos_q; mem_wdata = ti_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSeed:   seed_d = cfg_data_i;
        CfgLength: plen_d = (cfg_len > 64'(MaxLength)) ? MaxLen : LW'(cfg_data_i[17:0]);
        default:   ;
      endcase
    end
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KindRead) begin
            pos_d = AW'(position_i);
            err_d = !once_q || ({{(64-17){1'b0}}, position_i} >= 64'(llen_q));
            st_d = S_RD0;
          end else begin
            epoch_d = epoch_i;
            len_d = plen_q;
            i_d = '0;
            st_d = S_FILL;
          end
        end
      end
      S_RD0: begin
        mem_re = !err_q; st_d = S_RD1;
      end
      S_RD1: begin
        val_d = err_q ? 17'd0 : mem_rdata;
        ovalid_d = 1'b1; st_d = S_RDOUT;
      end
      S_RDOUT: if (!ovalid_q) st_d = S_IDLE;
      S_FILL: begin
        if (i_q == len_q) begin
          z_d = seed_q; hsel_d = H_SEED; st_d = S_SM_ADD;
        end else begin
          mem_we = 1'b1; mem_addr = i_q[AW-1:0]; mem_wdata = 17'(i_q);
          i_d = i_q + LW'(1);
        end
      end
      S_SM_ADD: begin
        z_d = z_q + SmGamma; st_d = S_SM_M1;
      end
      S_SM_M1: begin
        mreq.start = 1'b1; mreq.a = z_q ^ (z_q >> 30); mreq.b = SmMul1;
        st_d = S_SM_W1;
      end
      S_SM_W1: if (mrsp.done) begin z_d = mrsp.prod; st_d = S_SM_M2; end
      S_SM_M2: begin
        mreq.start = 1'b1; mreq.a = z_q ^ (z_q >> 27); mreq.b = SmMul2;
        st_d = S_SM_W2;
      end
      S_SM_W2: if (mrsp.done) begin z_d = mrsp.prod; st_d = S_SM_FIN; end
      S_SM_FIN: begin
        h_d = z_q ^ (z_q >> 31);
        case (hsel_q)
          H_SEED: begin
            smix_d = z_q ^ (z_q >> 31);
            i_d = len_q; st_d = S_LOOP;
          end
          H_KEY: begin
            z_d = smix_q ^ (z_q ^ (z_q >> 31)); hsel_d = H_MID; st_d = S_SM_ADD;
          end
          H_MID: begin
            z_d = z_q ^ (z_q >> 31); hsel_d = H_OUT; st_d = S_SM_ADD;
          end
          default: st_d = S_DIV;
        endcase
      end
      S_LOOP: begin
        if (i_q == '0) begin
          llen_d = len_q; once_d = 1'b1; st_d = S_IDLE;
        end else begin
          i_d = i_q - LW'(1); st_d = S_MULE;
        end
      end
      S_MULE: begin
        mreq.start = 1'b1; mreq.a = {32'd0, epoch_q}; mreq.b = 64'(len_q);
        st_d = S_MULEW;
      end
      S_MULEW: if (mrsp.done) begin
        z_d = mrsp.prod + 64'(i_q); hsel_d = H_KEY; st_d = S_SM_ADD;
      end
      S_DIV: begin dstart = 1'b1; st_d = S_DIVW; end
      S_DIVW: if (ddone) begin j_d = drem[AW-1:0]; st_d = S_SW0; end
      S_SW0: begin
        mem_re = 1'b1; mem_addr = i_q[AW-1:0]; st_d = S_SW1;
      end
      S_SW1: begin
        ti_d = mem_rdata; mem_re = 1'b1; mem_addr = j_q; st_d = S_SW2;
      end
      S_SW2: begin
        mem_we = 1'b1; mem_addr = i_q[AW-1:0]; mem_wdata = mem_rdata;
        st_d = S_SW3;
      end
      S_SW3: begin
        mem_we = 1'b1; mem_addr = j_q; mem_wdata = ti_q; st_d = S_LOOP;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; seed_q <= '0; plen_q <= MaxLen; llen_q <= '0;
      once_q <= 1'b0; ovalid_q <= 1'b0; hsel_q <= H_SEED;
    end else begin
      st_q <= st_d; seed_q <= seed_d; plen_q <= plen_d; llen_q <= llen_d;
      once_q <= once_d; ovalid_q <= ovalid_d; hsel_q <= hsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d; smix_q <= smix_d; z_q <= z_d; h_q <= h_d;
    epoch_q <= epoch_d; i_q <= i_d; j_q <= j_d; pos_q <= pos_d;
    ti_q <= ti_d; val_q <= val_d; err_q <= err_d;
  end

  assign in_stall_o    = (st_q != S_IDLE);
  assign out_valid_o   = ovalid_q;
  assign entry_value_o = val_q;
  assign read_error_o  = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && err_q) |-> val_q == 17'd0) else $error("error read not zero");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q && $stable(val_q))
    else $error("result dropped under stall");
  a_swap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SW0) |-> {1'b0, j_q} <= i_q) else $error("swap index out of range");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= MaxLen) else $error("length above maximum");
endmodule
`default_nettype wire

// ===== design/sps_mul64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sps_mul64
// Shared 64x64 wrapping multiplier, one 16x64 partial product per cycle.
// ----------------------------------------------------------------------------
module sps_mul64 (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sps_pkg::mul_req_t req_i,
  output sps_pkg::mul_rsp_t      rsp_o
);
  import sps_pkg::*;

  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d = a_q; b_d = b_q; acc_d = acc_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      a_d = req_i.a; b_d = req_i.b; acc_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      // add the partial product of the next 16-bit slice of b
      acc_d = acc_q + ((a_q * {48'd0, b_q[15:0]}) << {cnt_q[1:0], 4'd0});
      b_d = b_q >> 16;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd3) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("multiplier done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("multiplier did not start");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < 3'd4) else $error("multiplier count overrun");
endmodule
`default_nettype wire

// ===== design/sps_divmod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sps_divmod
// Restoring remainder unit: 64-bit dividend modulo a narrow divisor, one bit
// per cycle.
// ----------------------------------------------------------------------------
module sps_divmod #(
  parameter int unsigned DW = 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [DW-1:0]      rem_o
);
  logic [63:0]   num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_q, rem_d, trial;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    num_d = num_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DW-1:0], num_q[63]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;
      num_d = num_q << 1;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DW-1:0];

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < {1'b0, den_q}) else $error("remainder not reduced");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
endmodule
`default_nettype wire
